[design/font_text_rect_renderer_core_defines.svh]
// Assertion macros for the checker file of the text renderer.
`ifndef FONT_TEXT_RECT_RENDERER_CORE_DEFINES_SVH
`define FONT_TEXT_RECT_RENDERER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FTR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ftr_pkg.sv]
package ftr_pkg;

	localparam int unsigned DEF_SCREEN_WIDTH  = 480;
	localparam int unsigned DEF_SCREEN_HEIGHT = 320;
	localparam int unsigned DEF_MAX_SCALE     = 8;

	localparam logic [7:0] FIRST_CODE   = 8'h20;
	localparam logic [7:0] LAST_CODE    = 8'h7E;
	localparam logic [7:0] SUBST_CODE   = 8'h3F;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_CHAR  = 1'b1;

	localparam int unsigned GLYPH_COUNT = 95;
	localparam int unsigned GLYPH_COLS  = 5;
	localparam int unsigned GLYPH_ROWS  = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_SPACE,
		ST_FLUSH
	} ftr_state_t;

	// Visibility and clipped size of one candidate rectangle.
	typedef struct packed {
		logic       vis;
		logic [3:0] w;
		logic [5:0] h;
	} ftr_clip_t;

	// Column-major 5x7 font, bit n of a column byte is glyph row n.
	localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
		'{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
		'{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
		'{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
		'{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
		'{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
		'{8'h08,8'h2A,8'h1C,8'h2A,8'h08}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
		'{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
		'{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
		'{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
		'{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
		'{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
		'{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
		'{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
		'{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
		'{8'h00,8'h08,8'h14,8'h22,8'h41}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
		'{8'h41,8'h22,8'h14,8'h08,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
		'{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
		'{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
		'{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
		'{8'h7F,8'h09,8'h09,8'h01,8'h01}, '{8'h3E,8'h41,8'h41,8'h51,8'h32},
		'{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
		'{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
		'{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h04,8'h02,8'h7F},
		'{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
		'{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
		'{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
		'{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
		'{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F},
		'{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h03,8'h04,8'h78,8'h04,8'h03},
		'{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h00,8'h7F,8'h41,8'h41},
		'{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h41,8'h41,8'h7F,8'h00,8'h00},
		'{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
		'{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
		'{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
		'{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
		'{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h08,8'h14,8'h54,8'h54,8'h3C},
		'{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
		'{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h00,8'h7F,8'h10,8'h28,8'h44},
		'{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
		'{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
		'{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h18,8'h7C},
		'{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
		'{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
		'{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
		'{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
		'{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
		'{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
		'{8'h08,8'h04,8'h08,8'h10,8'h08}
	};

endpackage

[design/ftr_clip.sv]
// Screen test and edge clipping for one candidate rectangle.
module ftr_clip #(
	parameter int unsigned SCREEN_WIDTH  = ftr_pkg::DEF_SCREEN_WIDTH,
	parameter int unsigned SCREEN_HEIGHT = ftr_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic [15:0]        x,
	input  logic [15:0]        y,
	input  logic [3:0]         w,
	input  logic [6:0]         h,
	output ftr_pkg::ftr_clip_t res
);
	import ftr_pkg::*;

	localparam logic [16:0] SW = 17'(SCREEN_WIDTH);
	localparam logic [16:0] SH = 17'(SCREEN_HEIGHT);

	logic [16:0] x_end;
	logic [16:0] y_end;
	logic [16:0] w_room;
	logic [16:0] h_room;
	logic [6:0]  h_clip;

	always_comb begin
		x_end  = {1'b0, x} + 17'(w);
		y_end  = {1'b0, y} + 17'(h);
		w_room = SW - {1'b0, x};
		h_room = SH - {1'b0, y};
		h_clip = (y_end > SH) ? h_room[6:0] : h;
		res.vis = ({1'b0, x} < SW) && ({1'b0, y} < SH);
		res.w   = (x_end > SW) ? w_room[3:0] : w;
		res.h   = h_clip[5:0];
	end

endmodule

[design/font_text_rect_renderer_core.sv]
// 5x7 bitmap font text renderer producing clipped fill rectangles.
//
// Input channel (in_valid/in_stall): a start transaction (kind 0) latches the
// string origin, the cursor, the RGB565 colours and the glyph scale; a
// character transaction (kind 1) draws one glyph at the cursor and advances it.
// A newline character only moves the cursor and produces no output.
// Output channel (out_valid/out_stall): one transaction per visible rectangle,
// colours as RGB565 fields widened to bytes, with last set on the final rectangle of a glyph.
// A start or newline transaction leaves the input free for the next one. A
// printable character is an accept step, 35 cell steps, seven spacing steps
// at scale 1 or one at larger scales, and one flush step. The cell sequencer
// walks the glyph through one shared position/clip unit, one rect a step; the
// input is stalled until the glyph is finished.
// One rectangle is held back in a pending register so that last can be set
// once it is known that no later rectangle is visible; a stall at the output
// only halts the sequencer when both the pending and the output register hold.
// Reset clears the cursor, origin and colours to zero and the scale to one.
module font_text_rect_renderer_core #(
	parameter int unsigned SCREEN_WIDTH  = ftr_pkg::DEF_SCREEN_WIDTH,
	parameter int unsigned SCREEN_HEIGHT = ftr_pkg::DEF_SCREEN_HEIGHT,
	parameter int unsigned MAX_SCALE     = ftr_pkg::DEF_MAX_SCALE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] start_x,
	input  logic [15:0] start_y,
	input  logic [7:0]  char_code,
	input  logic [15:0] fg_color,
	input  logic [15:0] bg_color,
	input  logic [3:0]  scale,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [8:0]  rect_x,
	output logic [8:0]  rect_y,
	output logic [3:0]  rect_w,
	output logic [5:0]  rect_h,
	output logic [7:0]  red_byte,
	output logic [7:0]  green_byte,
	output logic [7:0]  blue_byte,
	output logic        last
);
	import ftr_pkg::*;

	localparam logic [16:0] SW      = 17'(SCREEN_WIDTH);
	localparam logic [4:0]  MAX_SC  = 5'(MAX_SCALE);

	// Persistent string state.
	logic [15:0] origin_col_q;
	logic [15:0] cursor_col_q;
	logic [15:0] cursor_row_q;
	logic [15:0] fore_q;
	logic [15:0] back_q;
	logic [3:0]  scale_q;

	// Glyph walk state.
	ftr_state_t  state_q;
	ftr_state_t  state_d;
	logic [6:0]  idx_q;
	logic [2:0]  col_q;
	logic [2:0]  row_q;
	logic [15:0] cx_q;
	logic [15:0] cy_q;
	logic [15:0] base_y_q;

	// Rectangle held back until the next visible one or the end of the glyph.
	logic        pend_valid_q;
	logic [8:0]  pend_x_q;
	logic [8:0]  pend_y_q;
	logic [3:0]  pend_w_q;
	logic [5:0]  pend_h_q;
	logic [15:0] pend_colour_q;

	// Output register.
	logic        out_valid_q;
	logic [8:0]  rect_x_q;
	logic [8:0]  rect_y_q;
	logic [3:0]  rect_w_q;
	logic [5:0]  rect_h_q;
	logic [15:0] out_colour_q;
	logic        last_q;

	logic        in_acc;
	logic        is_newline;
	logic [3:0]  scale_in;
	logic [6:0]  six_s;
	logic [7:0]  line_step;
	logic [16:0] wrap_sum;
	logic        wrap;
	logic [15:0] x0;
	logic [15:0] y0;
	logic [7:0]  code_fix;
	logic [7:0]  glyph_col;
	logic        cell_on;
	logic        walking;
	logic [3:0]  cand_w;
	logic [6:0]  cand_h;
	logic [15:0] cand_colour;
	ftr_clip_t   clip;
	logic        out_free;
	logic        step_go;
	logic        push;
	logic        flush_done;
	logic        last_row;
	logic        space_done;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign is_newline = (char_code == NEWLINE_CODE);

	// Scale clamp for the start transaction.
	always_comb begin
		if (scale == 4'd0) begin
			scale_in = 4'd1;
		end else if ({1'b0, scale} > MAX_SC) begin
			scale_in = MAX_SC[3:0];
		end else begin
			scale_in = scale;
		end
	end

	// Cursor arithmetic for a character: wrap test on the unwrapped sum.
	always_comb begin
		six_s     = {1'b0, scale_q, 2'b00} + {2'b00, scale_q, 1'b0};
		line_step = {1'b0, scale_q, 3'b000} - {4'd0, scale_q} + 8'd2;
		wrap_sum  = {1'b0, cursor_col_q} + 17'(six_s);
		wrap      = wrap_sum > SW;
		x0        = wrap ? origin_col_q : cursor_col_q;
		y0        = wrap ? (cursor_row_q + 16'(line_step)) : cursor_row_q;
		if (char_code < FIRST_CODE || char_code > LAST_CODE) begin
			code_fix = SUBST_CODE;
		end else begin
			code_fix = char_code;
		end
	end

	// Candidate rectangle of the current step.
	always_comb begin
		glyph_col = GLYPH_ROM[idx_q][col_q];
		cell_on   = glyph_col[row_q];
		walking   = (state_q == ST_CELL) || (state_q == ST_SPACE);
		if (state_q == ST_CELL) begin
			cand_w      = scale_q;
			cand_h      = {3'd0, scale_q};
			cand_colour = cell_on ? fore_q : back_q;
		end else if (scale_q == 4'd1) begin
			cand_w      = 4'd1;
			cand_h      = 7'd1;
			cand_colour = back_q;
		end else begin
			cand_w      = scale_q;
			cand_h      = {scale_q, 3'b000} - {3'd0, scale_q};
			cand_colour = back_q;
		end
	end

	ftr_clip #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_clip (
		.x  (cx_q),
		.y  (cy_q),
		.w  (cand_w),
		.h  (cand_h),
		.res(clip)
	);

	// Handshake between the walk, the pending register and the output register.
	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		step_go    = walking && !(clip.vis && pend_valid_q && !out_free);
		flush_done = (state_q == ST_FLUSH) && (!pend_valid_q || out_free);
		push       = (step_go && clip.vis && pend_valid_q) ||
			((state_q == ST_FLUSH) && pend_valid_q && out_free);
		last_row   = (row_q == 3'(GLYPH_ROWS - 1));
		space_done = (scale_q != 4'd1) || last_row;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && kind == KIND_CHAR && !is_newline) begin
					state_d = ST_CELL;
				end
			end
			ST_CELL: begin
				if (step_go && last_row && col_q == 3'(GLYPH_COLS - 1)) begin
					state_d = ST_SPACE;
				end
			end
			ST_SPACE: begin
				if (step_go && space_done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// String state and cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_col_q <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			fore_q       <= '0;
			back_q       <= '0;
			scale_q      <= 4'd1;
		end else if (in_acc) begin
			if (kind == KIND_START) begin
				origin_col_q <= start_x;
				cursor_col_q <= start_x;
				cursor_row_q <= start_y;
				fore_q       <= fg_color;
				back_q       <= bg_color;
				scale_q      <= scale_in;
			end else if (is_newline) begin
				cursor_col_q <= origin_col_q;
				cursor_row_q <= cursor_row_q + 16'(line_step);
			end else begin
				cursor_col_q <= x0 + 16'(six_s);
				cursor_row_q <= y0;
			end
		end
	end

	// Glyph walk: cells go down each column, then across; the spacing column
	// reuses the same position registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q    <= 7'(code_fix - FIRST_CODE);
			col_q    <= '0;
			row_q    <= '0;
			cx_q     <= x0;
			cy_q     <= y0;
			base_y_q <= y0;
		end else if (step_go) begin
			if (state_q == ST_CELL) begin
				if (last_row) begin
					row_q <= '0;
					cy_q  <= base_y_q;
					cx_q  <= cx_q + 16'(scale_q);
					if (col_q != 3'(GLYPH_COLS - 1)) begin
						col_q <= col_q + 3'd1;
					end
				end else begin
					row_q <= row_q + 3'd1;
					cy_q  <= cy_q + 16'(scale_q);
				end
			end else begin
				row_q <= row_q + 3'd1;
				cy_q  <= cy_q + 16'd1;
			end
		end
	end

	// Pending rectangle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (step_go && clip.vis) begin
			pend_valid_q <= 1'b1;
		end else if (flush_done) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && clip.vis) begin
			pend_x_q      <= cx_q[8:0];
			pend_y_q      <= cy_q[8:0];
			pend_w_q      <= clip.w;
			pend_h_q      <= clip.h;
			pend_colour_q <= cand_colour;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && push) begin
			rect_x_q     <= pend_x_q;
			rect_y_q     <= pend_y_q;
			rect_w_q     <= pend_w_q;
			rect_h_q     <= pend_h_q;
			out_colour_q <= pend_colour_q;
			last_q       <= (state_q == ST_FLUSH);
		end
	end

	assign out_valid  = out_valid_q;
	assign rect_x     = rect_x_q;
	assign rect_y     = rect_y_q;
	assign rect_w     = rect_w_q;
	assign rect_h     = rect_h_q;
	assign red_byte   = {out_colour_q[15:11], 3'b000};
	assign green_byte = {out_colour_q[10:5], 2'b00};
	assign blue_byte  = {out_colour_q[4:0], 3'b000};
	assign last       = last_q;

endmodule

[design/ftr_checker.sv]
`include "font_text_rect_renderer_core_defines.svh"

// Port-level checks on the text renderer.
module ftr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        kind,
	input logic [15:0] start_x,
	input logic [15:0] start_y,
	input logic [7:0]  char_code,
	input logic [15:0] fg_color,
	input logic [15:0] bg_color,
	input logic [3:0]  scale,
	input logic        out_valid,
	input logic        out_stall,
	input logic [8:0]  rect_x,
	input logic [8:0]  rect_y,
	input logic [3:0]  rect_w,
	input logic [5:0]  rect_h,
	input logic [7:0]  red_byte,
	input logic [7:0]  green_byte,
	input logic [7:0]  blue_byte,
	input logic        last
);
	import ftr_pkg::*;

	`FTR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(rect_x) && $stable(rect_y) && $stable(last),
		"stalled output transaction changed")

	`FTR_ASSERT_NXT(a_char_busy, clk, arst_n,
		in_valid && !in_stall && kind == KIND_CHAR && char_code != NEWLINE_CODE,
		in_stall, "input not stalled while a glyph is drawn")

	`FTR_ASSERT_NXT(a_start_silent, clk, arst_n,
		in_valid && !in_stall && kind == KIND_START, !$rose(out_valid),
		"output appeared after a start transaction")

	`FTR_ASSERT_IMP(a_rect_size, clk, arst_n, out_valid,
		rect_w != 4'd0 && red_byte[2:0] == 3'b000 && blue_byte[2:0] == 3'b000,
		"empty rectangle or malformed colour on output")

endmodule

bind font_text_rect_renderer_core ftr_checker u_ftr_checker (.*);

[tb/font_text_rect_renderer_core_tb.sv]
import ftr_pkg::*;

// One input transaction, all fields present whatever the kind.
typedef struct {
	logic        kind;
	logic [15:0] start_x;
	logic [15:0] start_y;
	logic [7:0]  char_code;
	logic [15:0] fg_color;
	logic [15:0] bg_color;
	logic [3:0]  scale;
} text_item_t;

// One clipped fill rectangle as it leaves the block.
typedef struct packed {
	logic [8:0] x;
	logic [8:0] y;
	logic [3:0] w;
	logic [5:0] h;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last;
} rect_t;

typedef enum int {
	PACE_FULL,
	PACE_RANDOM,
	PACE_SPARSE
} pace_t;

// Keeps its own cursor, colours and scale, expands every accepted character
// into the rectangles it should produce and checks the output against them.
class glyph_rect_scoreboard;
	logic [15:0] origin_col;
	logic [15:0] cursor_col;
	logic [15:0] cursor_row;
	logic [15:0] fore;
	logic [15:0] back;
	logic [3:0]  glyph_scale;
	rect_t       pending_rects[$];
	int n_start, n_char, n_newline, n_wrap, n_subst;
	int n_checked, n_clipped, n_dropped, n_errors;

	function new();
		origin_col  = '0;
		cursor_col  = '0;
		cursor_row  = '0;
		fore        = '0;
		back        = '0;
		glyph_scale = 4'd1;
	endfunction

	function void next_row();
		cursor_col = origin_col;
		cursor_row = cursor_row + 16'(7 * glyph_scale + 2);
	endfunction

	function void add_rect(int unsigned x, int unsigned y, int unsigned side_w,
			int unsigned side_h, logic [15:0] colour);
		rect_t r;
		x = x % 65536;
		y = y % 65536;
		if (x >= DEF_SCREEN_WIDTH || y >= DEF_SCREEN_HEIGHT) begin
			n_dropped++;
			return;
		end
		if (x + side_w > DEF_SCREEN_WIDTH || y + side_h > DEF_SCREEN_HEIGHT)
			n_clipped++;
		if (x + side_w > DEF_SCREEN_WIDTH)
			side_w = DEF_SCREEN_WIDTH - x;
		if (y + side_h > DEF_SCREEN_HEIGHT)
			side_h = DEF_SCREEN_HEIGHT - y;
		r.x     = 9'(x);
		r.y     = 9'(y);
		r.w     = 4'(side_w);
		r.h     = 6'(side_h);
		r.red   = {colour[15:11], 3'b000};
		r.green = {colour[10:5], 2'b00};
		r.blue  = {colour[4:0], 3'b000};
		r.last  = 1'b0;
		pending_rects.push_back(r);
	endfunction

	function void note_item(text_item_t it);
		int unsigned s, col, row, base;
		logic [7:0] code;
		logic [7:0] bits;
		rect_t tail;
		if (it.kind == KIND_START) begin
			n_start++;
			if (it.scale == 4'd0)
				glyph_scale = 4'd1;
			else if (it.scale > DEF_MAX_SCALE)
				glyph_scale = 4'(DEF_MAX_SCALE);
			else
				glyph_scale = it.scale;
			origin_col = it.start_x;
			cursor_col = it.start_x;
			cursor_row = it.start_y;
			fore       = it.fg_color;
			back       = it.bg_color;
			return;
		end
		n_char++;
		if (it.char_code == NEWLINE_CODE) begin
			n_newline++;
			next_row();
			return;
		end
		s = 32'(glyph_scale);
		// The wrap test uses the full sum, before any 16-bit wrap.
		if (cursor_col + 6 * s > DEF_SCREEN_WIDTH) begin
			n_wrap++;
			next_row();
		end
		code = it.char_code;
		if (code < FIRST_CODE || code > LAST_CODE) begin
			n_subst++;
			code = SUBST_CODE;
		end
		base = pending_rects.size();
		for (col = 0; col < GLYPH_COLS; col++) begin
			bits = GLYPH_ROM[code - FIRST_CODE][col];
			for (row = 0; row < GLYPH_ROWS; row++)
				add_rect(cursor_col + col * s, cursor_row + row * s, s, s,
					bits[row] ? fore : back);
		end
		if (s == 1) begin
			for (row = 0; row < GLYPH_ROWS; row++)
				add_rect(cursor_col + 5, cursor_row + row, 1, 1, back);
		end else begin
			add_rect(cursor_col + 5 * s, cursor_row, s, 7 * s, back);
		end
		cursor_col = cursor_col + 16'(6 * s);
		if (pending_rects.size() > base) begin
			tail = pending_rects.pop_back();
			tail.last = 1'b1;
			pending_rects.push_back(tail);
		end
	endfunction

	function void compare(string field, logic [8:0] want, logic [8:0] got);
		if (got !== want) begin
			n_errors++;
			$error("%s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	function void check_rect(rect_t got);
		rect_t want;
		if (pending_rects.size() == 0) begin
			n_errors++;
			$error("rectangle at (%0d,%0d) arrived with none outstanding", got.x, got.y);
			return;
		end
		want = pending_rects.pop_front();
		n_checked++;
		compare("rect_x", want.x, got.x);
		compare("rect_y", want.y, got.y);
		compare("rect_w", 9'(want.w), 9'(got.w));
		compare("rect_h", 9'(want.h), 9'(got.h));
		compare("red_byte", 9'(want.red), 9'(got.red));
		compare("green_byte", 9'(want.green), 9'(got.green));
		compare("blue_byte", 9'(want.blue), 9'(got.blue));
		compare("last", 9'(want.last), 9'(got.last));
	endfunction
endclass

module font_text_rect_renderer_core_tb;

	// The slowest correct character is 42 rectangles, each of which may wait
	// out a drawn output stall, plus the sender's gap; the limit allows for
	// several times that over every transaction of the run.
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 205;
	localparam int DRAIN_CYCLES = 64;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [15:0] start_x;
	logic [15:0] start_y;
	logic [7:0]  char_code;
	logic [15:0] fg_color;
	logic [15:0] bg_color;
	logic [3:0]  scale;
	logic        out_valid;
	logic        out_stall;
	logic [8:0]  rect_x;
	logic [8:0]  rect_y;
	logic [3:0]  rect_w;
	logic [5:0]  rect_h;
	logic [7:0]  red_byte;
	logic [7:0]  green_byte;
	logic [7:0]  blue_byte;
	logic        last;

	glyph_rect_scoreboard board;
	pace_t in_pace;
	pace_t out_pace;
	int    items_sent;
	int    cycle_count;

	font_text_rect_renderer_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.start_x    (start_x),
		.start_y    (start_y),
		.char_code  (char_code),
		.fg_color   (fg_color),
		.bg_color   (bg_color),
		.scale      (scale),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.red_byte   (red_byte),
		.green_byte (green_byte),
		.blue_byte  (blue_byte),
		.last       (last)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Idle cycles before the next transaction on either side. The pace is
	// redrawn every few dozen transactions, so that long back-to-back
	// stretches alternate with heavy and with occasional idling.
	function automatic int draw_wait(pace_t pace);
		case (pace)
			PACE_FULL:   return 0;
			PACE_RANDOM: return $urandom_range(0, 8);
			default:     return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
		endcase
	endfunction

	// Every field random, the kind included. The helpers below overwrite the
	// fields that matter, so the unused fields still carry random bits.
	function automatic text_item_t noise_item();
		text_item_t it;
		it.kind      = 1'($urandom_range(0, 1));
		it.start_x   = 16'($urandom_range(0, 65535));
		it.start_y   = 16'($urandom_range(0, 65535));
		it.char_code = 8'($urandom_range(0, 255));
		it.fg_color  = 16'($urandom_range(0, 65535));
		it.bg_color  = 16'($urandom_range(0, 65535));
		it.scale     = 4'($urandom_range(0, 15));
		return it;
	endfunction

	function automatic text_item_t start_item(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] fg, input logic [15:0] bg, input logic [3:0] sc);
		text_item_t it;
		it          = noise_item();
		it.kind     = KIND_START;
		it.start_x  = x;
		it.start_y  = y;
		it.fg_color = fg;
		it.bg_color = bg;
		it.scale    = sc;
		return it;
	endfunction

	function automatic text_item_t char_item(input logic [7:0] code);
		text_item_t it;
		it           = noise_item();
		it.kind      = KIND_CHAR;
		it.char_code = code;
		return it;
	endfunction

	// Mostly printable text, with the odd newline and the odd arbitrary byte.
	function automatic logic [7:0] draw_code();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return NEWLINE_CODE;
		if (pick == 1)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(FIRST_CODE, LAST_CODE));
	endfunction

	// Presents one transaction at a falling edge and holds it until a rising
	// edge sees valid without stall. The valid line is only lowered when an
	// idle gap is drawn, so back-to-back transactions keep it high.
	task automatic send_item(input text_item_t it);
		int gap;
		if (items_sent % 25 == 0)
			in_pace = pace_t'($urandom_range(0, 2));
		gap = draw_wait(in_pace);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= it.kind;
		start_x   <= it.start_x;
		start_y   <= it.start_y;
		char_code <= it.char_code;
		fg_color  <= it.fg_color;
		bg_color  <= it.bg_color;
		scale     <= it.scale;
		do @(posedge clk); while (in_stall);
		board.note_item(it);
		items_sent++;
	endtask

	// Output side: before each rectangle a number of stall cycles is drawn,
	// then the stall is released until one transaction has been taken.
	initial begin : out_pacing
		int gap;
		int taken;
		taken = 0;
		out_pace = PACE_RANDOM;
		forever begin
			if (taken % 40 == 0)
				out_pace = pace_t'($urandom_range(0, 2));
			gap = draw_wait(out_pace);
			@(negedge clk);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			taken++;
		end
	end

	// Every rectangle accepted at a rising edge is checked against the
	// oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_rect('{rect_x, rect_y, rect_w, rect_h,
				red_byte, green_byte, blue_byte, last});
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("no completion after %0d cycles, %0d rectangles outstanding",
				CYCLE_LIMIT, board.pending_rects.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int first_random;
		int len;
		int n;
		logic [15:0] x;
		logic [15:0] y;
		logic [3:0]  sc;

		board       = new();
		items_sent  = 0;
		cycle_count = 0;
		in_pace     = PACE_FULL;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		kind        = KIND_START;
		start_x     = '0;
		start_y     = '0;
		char_code   = '0;
		fg_color    = '0;
		bg_color    = '0;
		scale       = '0;
		out_stall   = 1'b0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// A character straight after reset uses the reset cursor, black on
		// black, at scale one.
		send_item(char_item(8'h41));

		// White on black at scale one: both ends of the printable range,
		// unprintable codes either side of it and at the byte extremes, and
		// a newline.
		send_item(start_item(16'd0, 16'd0, 16'hFFFF, 16'h0000, 4'd0 + 4'd1));
		send_item(char_item(FIRST_CODE));
		send_item(char_item(LAST_CODE));
		send_item(char_item(8'h00));
		send_item(char_item(8'hFF));
		send_item(char_item(8'h7F));
		send_item(char_item(8'h1F));
		send_item(char_item(NEWLINE_CODE));
		send_item(char_item(8'h40));

		// A zero scale is taken as one; the origin sits so close to the
		// bottom-right corner that the glyph wraps to a row below the screen.
		send_item(start_item(16'd476, 16'd316, 16'hF800, 16'h07E0, 4'd0));
		send_item(char_item(8'h57));

		// A scale above the maximum is limited to it; a newline at a large
		// scale moves the cursor by seven cells plus two rows.
		send_item(start_item(16'd0, 16'd0, 16'hA5A5, 16'h5A5A, 4'd15));
		send_item(char_item(8'h23));
		send_item(char_item(NEWLINE_CODE));
		send_item(char_item(8'h4D));

		// Coordinates near the top of the 16-bit range wrap round to the
		// left and top of the screen after the line wrap.
		send_item(start_item(16'd65530, 16'd65535, 16'h001F, 16'hFFE0, 4'd8));
		send_item(char_item(8'h48));

		// Glyphs that land wholly off screen produce nothing at all.
		send_item(start_item(16'd479, 16'd319, 16'hFFFF, 16'hFFFF, 4'd2));
		send_item(char_item(8'h58));
		send_item(start_item(16'd600, 16'd600, 16'h1234, 16'h4321, 4'd1));
		send_item(char_item(8'h4F));

		// Random part: mostly strings, each a start transaction followed by
		// a run of characters, with some lone transactions of random kind.
		first_random = items_sent;
		while (items_sent - first_random < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(noise_item());
			end else begin
				case ($urandom_range(0, 4))
					0: begin
						x = 16'($urandom_range(0, 65535));
						y = 16'($urandom_range(0, 65535));
					end
					1: begin
						x = 16'($urandom_range(440, 479));
						y = 16'($urandom_range(280, 319));
					end
					2: begin
						x = 16'($urandom_range(65500, 65535));
						y = 16'($urandom_range(0, 319));
					end
					default: begin
						x = 16'($urandom_range(0, 479));
						y = 16'($urandom_range(0, 319));
					end
				endcase
				sc = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 3))
					: 4'($urandom_range(0, 15));
				send_item(start_item(x, y, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), sc));
				len = $urandom_range(1, 14);
				for (n = 0; n < len; n++)
					send_item(char_item(draw_code()));
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Let every predicted rectangle come out, then give the block time
		// to show any surplus one.
		while (board.pending_rects.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d string starts and %0d characters:",
			board.n_start, board.n_char);
		$display("  %0d newlines, %0d wraps, %0d substituted codes.",
			board.n_newline, board.n_wrap, board.n_subst);
		$display("Compared %0d rectangles; %0d predicted clipped, %0d dropped.",
			board.n_checked, board.n_clipped, board.n_dropped);
		if (board.n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
